/* design/evad_pkg.sv */
// shared constants and types for the energy voice activity detector
`default_nettype none

package evad_pkg;

  localparam int unsigned SampleW      = 16;
  localparam int unsigned EnergyW      = 16;
  localparam int unsigned BgW          = 32;
  localparam int unsigned ThrW         = 16;
  localparam int unsigned MulAW        = 32;
  localparam int unsigned MulBW        = 16;
  localparam int unsigned MulPW        = MulAW + MulBW;
  localparam int unsigned SquareW      = 30;  // largest square is 2^30
  localparam int unsigned SqrtInW      = 32;  // radicand, even width
  localparam int unsigned SqrtSteps    = SqrtInW / 2;
  localparam int unsigned SqrtRemW     = 19;  // partial remainder after the two-bit shift
  localparam int unsigned OutDataW     = 40;

  localparam int unsigned WindowDef    = 16;
  localparam int unsigned FrameMaxDef  = 4096;

  localparam logic [MulBW-1:0] AlphaNum     = 16'd655;
  localparam logic [MulBW-1:0] OneMinusAlph = 16'd64881;
  localparam logic [ThrW-1:0]  ThrReset     = 16'd512;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqClear  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_SQRT_LOAD,
    ST_SQRT_RUN,
    ST_BG_MUL,
    ST_BG_MUL2,
    ST_BG_ADD,
    ST_RING_UPD,
    ST_MEAN_LOAD,
    ST_MEAN_RUN,
    ST_VOICE_MUL,
    ST_RESULT
  } evad_state_e;

  typedef enum logic [1:0] {
    MUL_SQUARE,
    MUL_DECAY,
    MUL_ALPHA,
    MUL_THRESH
  } evad_mul_sel_e;

endpackage

`default_nettype wire

/* design/energy_vad_adaptive_background_top.sv */
// energy voice activity detector with adaptive background, iterative datapath
//
//  channel   dir  handshake           payload
//  s_axis    in   tvalid/tready       tdata[15:0] sample, tuser req_type, tlast last_of_frame
//  m_axis    out  tvalid/tready       tdata[0] voice_active, [16:1] frame_energy,
//                                     [32:17] background_level, [39:33] zero
//  cfg       in   cfg_we_i            cfg_wdata_i threshold_factor (Q8.8)
//
//  a sample transfer steps through accept, square and accumulate, squaring on the shared multiplier
//  a frame end adds SumW steps of divide, 16 of square root and WsumW steps of mean divide
//    through one shared subtractor, plus the control states; a sample with no room left in
//    the frame and no last mark is accepted and discarded
//  a clear transfer produces no result
//  rst_ni is asynchronous; the ring memory is never cleared, only entries already written
//    are read back
//  a pending result sits in the output register and does not block the next transfer;
//    the next frame end waits in ST_RESULT until that register frees
`default_nettype none

module energy_vad_adaptive_background_top
  import evad_pkg::*;
#(
  parameter int unsigned WINDOW    = WindowDef,
  parameter int unsigned FRAME_MAX = FrameMaxDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [SampleW-1:0]   s_axis_tdata,   // [15:0] sample
  input  wire logic                 s_axis_tuser,   // [0] req_type
  input  wire logic                 s_axis_tlast,   // last_of_frame
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,   // [0] voice_active, [16:1] frame_energy,
                                                    // [32:17] background_level, rest zero
  input  wire logic                 cfg_we_i,
  input  wire logic [ThrW-1:0]      cfg_wdata_i     // threshold_factor
);

  // derived widths
  localparam int unsigned CntW   = $clog2(FRAME_MAX + 1);
  localparam int unsigned SumW   = SquareW + CntW;
  localparam int unsigned FillW  = $clog2(WINDOW + 1);
  localparam int unsigned PtrW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned WsumW  = EnergyW + FillW;
  localparam int unsigned NumW0  = (SumW > SqrtInW) ? SumW : SqrtInW;
  localparam int unsigned NumW   = (NumW0 > WsumW) ? NumW0 : WsumW;
  localparam int unsigned RemW0  = (CntW + 1 > SqrtRemW) ? CntW + 1 : SqrtRemW;
  localparam int unsigned RemW   = (RemW0 > FillW + 1) ? RemW0 : FillW + 1;
  localparam int unsigned IterW  = $clog2(NumW + 1);

  localparam logic [CntW-1:0]  FrameFull = CntW'(FRAME_MAX);
  localparam logic [FillW-1:0] FillFull  = FillW'(WINDOW);
  localparam logic [PtrW-1:0]  PtrLast   = PtrW'(WINDOW - 1);

  evad_state_e state_q, state_d;

  // control and datapath registers
  logic [ThrW-1:0]    thr_q;
  logic [SumW-1:0]    sum_q;
  logic [CntW-1:0]    cnt_q;
  logic [BgW-1:0]     bg_q;
  logic               first_q;
  logic [PtrW-1:0]    ptr_q;
  logic [FillW-1:0]   fill_q;
  logic [WsumW-1:0]   wsum_q;
  logic [MulBW-1:0]   mag_q;
  logic               last_q;
  logic [MulPW-1:0]   prod_q;
  logic [BgW-1:0]     decay_q;
  logic [EnergyW-1:0] energy_q;
  logic [NumW-1:0]    num_q;
  logic [NumW-1:0]    quo_q;
  logic [RemW-1:0]    rem_q;
  logic [RemW-1:0]    dvs_q;
  logic [IterW-1:0]   iter_q;
  logic [EnergyW-1:0] rd_q;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [EnergyW-1:0] ring_mem [WINDOW];

  // control decode
  logic               in_xfer;
  logic               out_free;
  logic               room;
  logic               sqrt_mode;
  evad_mul_sel_e      mul_sel;

  // shared units
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [MulPW-1:0]   mul_p;
  logic [RemW-1:0]    sh_div, sh_sq, alu_a, alu_b, rem_step;
  logic [RemW:0]      alu_diff;
  logic               alu_ok;
  logic [NumW-1:0]    num_step, quo_step;
  logic [MulBW-1:0]   mag_in;
  logic               bg_below;
  logic               voice;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign room     = (cnt_q != FrameFull);
  assign mag_in   = s_axis_tdata[SampleW-1] ? (MulBW'(0) - s_axis_tdata) : s_axis_tdata;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser == ReqSample)) begin
          if (room) begin
            state_d = ST_SQUARE;
          end else if (s_axis_tlast) begin
            state_d = ST_DIV_LOAD;
          end
        end
      end
      ST_SQUARE:    state_d = ST_ACCUM;
      ST_ACCUM:     state_d = last_q ? ST_DIV_LOAD : ST_IDLE;
      ST_DIV_LOAD:  state_d = ST_DIV_RUN;
      ST_DIV_RUN:   state_d = (iter_q == IterW'(1)) ? ST_SQRT_LOAD : ST_DIV_RUN;
      ST_SQRT_LOAD: state_d = ST_SQRT_RUN;
      ST_SQRT_RUN:  state_d = (iter_q == IterW'(1)) ? ST_BG_MUL : ST_SQRT_RUN;
      ST_BG_MUL:    state_d = (!first_q && bg_below) ? ST_BG_MUL2 : ST_RING_UPD;
      ST_BG_MUL2:   state_d = ST_BG_ADD;
      ST_BG_ADD:    state_d = ST_RING_UPD;
      ST_RING_UPD:  state_d = ST_MEAN_LOAD;
      ST_MEAN_LOAD: state_d = ST_MEAN_RUN;
      ST_MEAN_RUN:  state_d = (iter_q == IterW'(1)) ? ST_VOICE_MUL : ST_MEAN_RUN;
      ST_VOICE_MUL: state_d = ST_RESULT;
      ST_RESULT:    state_d = out_free ? ST_IDLE : ST_RESULT;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    sqrt_mode     = 1'b0;
    mul_sel       = MUL_SQUARE;
    case (state_q)
      ST_IDLE:      s_axis_tready = 1'b1;
      ST_SQRT_RUN:  sqrt_mode = 1'b1;
      ST_BG_MUL:    mul_sel = MUL_DECAY;
      ST_BG_MUL2:   mul_sel = MUL_ALPHA;
      ST_VOICE_MUL: mul_sel = MUL_THRESH;
      default:      mul_sel = MUL_SQUARE;
    endcase
  end

  // shared multiplier, operands by step
  always_comb begin
    case (mul_sel)
      MUL_SQUARE: begin
        mul_a = MulAW'(mag_q);
        mul_b = mag_q;
      end
      MUL_DECAY: begin
        mul_a = bg_q;
        mul_b = OneMinusAlph;
      end
      MUL_ALPHA: begin
        mul_a = MulAW'(energy_q);
        mul_b = AlphaNum;
      end
      MUL_THRESH: begin
        mul_a = bg_q;
        mul_b = thr_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

  // shared shift-subtract step: restoring divide or two-bit square root
  assign sh_div   = {rem_q[RemW-2:0], num_q[NumW-1]};
  assign sh_sq    = {rem_q[RemW-3:0], num_q[NumW-1:NumW-2]};
  assign alu_a    = sqrt_mode ? sh_sq : sh_div;
  assign alu_b    = sqrt_mode ? {quo_q[RemW-3:0], 2'b01} : dvs_q;
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ok   = !alu_diff[RemW];
  assign rem_step = alu_ok ? alu_diff[RemW-1:0] : alu_a;
  assign quo_step = {quo_q[NumW-2:0], alu_ok};
  assign num_step = sqrt_mode ? (num_q << 2) : (num_q << 1);

  // energy lies below twice the background, exact
  assign bg_below = ({1'b0, quo_q[EnergyW-1:0], 16'd0} < {bg_q, 1'b0});
  // mean * 2^24 against threshold times background
  assign voice    = (MulPW'({quo_q[EnergyW-1:0], 24'd0}) > prod_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= ThrReset;
      sum_q       <= '0;
      cnt_q       <= '0;
      bg_q        <= '0;
      first_q     <= 1'b1;
      ptr_q       <= '0;
      fill_q      <= '0;
      wsum_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // output register loads a finished result or drains on a transfer
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (s_axis_tuser == ReqClear)) begin
            sum_q   <= '0;
            cnt_q   <= '0;
            bg_q    <= '0;
            first_q <= 1'b1;
            ptr_q   <= '0;
            fill_q  <= '0;
            wsum_q  <= '0;
          end
        end
        ST_ACCUM: begin
          sum_q <= sum_q + SumW'(prod_q[SquareW:0]);
          cnt_q <= cnt_q + CntW'(1);
        end
        ST_DIV_LOAD: begin
          sum_q  <= '0;
          cnt_q  <= '0;
          iter_q <= IterW'(SumW);
        end
        ST_SQRT_LOAD: iter_q <= IterW'(SqrtSteps);
        ST_MEAN_LOAD: iter_q <= IterW'(WsumW);
        ST_DIV_RUN, ST_SQRT_RUN, ST_MEAN_RUN: iter_q <= iter_q - IterW'(1);
        ST_BG_MUL: begin
          if (first_q) begin
            bg_q    <= {quo_q[EnergyW-1:0], 16'd0};
            first_q <= 1'b0;
          end
        end
        ST_BG_ADD: bg_q <= decay_q + prod_q[BgW-1:0];
        ST_RING_UPD: begin
          if (fill_q == FillFull) begin
            wsum_q <= wsum_q - WsumW'(rd_q) + WsumW'(energy_q);
          end else begin
            fill_q <= fill_q + FillW'(1);
            wsum_q <= wsum_q + WsumW'(energy_q);
          end
          ptr_q <= (ptr_q == PtrLast) ? '0 : ptr_q + PtrW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mag_q  <= mag_in;
        last_q <= s_axis_tlast;
      end
      ST_SQUARE: prod_q <= mul_p;
      ST_DIV_LOAD: begin
        rem_q <= '0;
        quo_q <= '0;
        if (cnt_q == '0) begin
          num_q <= '0;
          dvs_q <= RemW'(1);
        end else begin
          num_q <= NumW'(sum_q) << (NumW - SumW);
          dvs_q <= RemW'(cnt_q);
        end
      end
      ST_SQRT_LOAD: begin
        rem_q <= '0;
        quo_q <= '0;
        num_q <= NumW'(quo_q[SqrtInW-1:0]) << (NumW - SqrtInW);
      end
      ST_MEAN_LOAD: begin
        rem_q <= '0;
        quo_q <= '0;
        num_q <= NumW'(wsum_q) << (NumW - WsumW);
        dvs_q <= RemW'(fill_q);
      end
      ST_DIV_RUN, ST_SQRT_RUN, ST_MEAN_RUN: begin
        rem_q <= rem_step;
        quo_q <= quo_step;
        num_q <= num_step;
      end
      ST_BG_MUL: begin
        energy_q <= quo_q[EnergyW-1:0];
        prod_q   <= mul_p;
      end
      ST_BG_MUL2: begin
        decay_q <= prod_q[MulPW-1:16];
        prod_q  <= mul_p;
      end
      ST_VOICE_MUL: prod_q <= mul_p;
      ST_RESULT: begin
        if (out_free) begin
          out_data_q <= {7'd0, bg_q[BgW-1:16], energy_q, voice};
        end
      end
      default: ;
    endcase
  end

  // energy ring, registered read of the slot about to be replaced
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_LOAD) begin
      rd_q <= ring_mem[ptr_q];
    end
    if (state_q == ST_RING_UPD) begin
      ring_mem[ptr_q] <= energy_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // fill count saturates at the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("ring fill above window depth");

  // write pointer stays inside the ring
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrLast)
    else $error("ring pointer out of range");

  // no ring entry is written before the first frame end has seeded the background
  a_first_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> (fill_q == '0))
    else $error("ring filled while background unset");

  // iterative steps never run with an exhausted step count
  a_iter_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_RUN || state_q == ST_SQRT_RUN || state_q == ST_MEAN_RUN)
      |-> (iter_q != '0))
    else $error("shift-subtract unit ran past its step count");

  // a finished result waits while the output register is still held
  a_result_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_valid_q && !m_axis_tready) |=>
      (state_q == ST_RESULT && out_valid_q))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
